// ----- hw/rtl/gsd_pkg.sv -----
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types and constants of the mixture-model shadow detector.
// ----------------------------------------------------------------------------
package gsd_pkg;

  // reason codes on decided_by
  localparam logic [1:0] REASON_SHADOW = 2'd0;
  localparam logic [1:0] REASON_ZERO   = 2'd1;
  localparam logic [1:0] REASON_WEIGHT = 2'd2;
  localparam logic [1:0] REASON_NONE   = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_BG_RATIO  = 2'd1;
  localparam logic [1:0] REG_TAU       = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd4096;
  localparam logic [15:0] BG_RATIO_RST  = 16'd58982;
  localparam logic [15:0] TAU_RST       = 16'd32768;

  localparam logic [18:0] WSUM_MAX = 19'h7FFFF;

  // one mode request as it travels through the queue
  typedef struct packed {
    logic [7:0]  pixel_c0;
    logic [7:0]  pixel_c1;
    logic [7:0]  pixel_c2;
    logic [15:0] mean_c0;
    logic [15:0] mean_c1;
    logic [15:0] mean_c2;
    logic [15:0] mode_weight;
    logic [15:0] mode_variance;
    logic        last_mode;
  } mode_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] bg_ratio;
    logic [15:0] tau;
  } cfg_t;

endpackage

// ----- hw/rtl/gsd_fifo.sv -----
// ----------------------------------------------------------------------------
// gsd_fifo
// Small register queue between the front and the back end.
// ----------------------------------------------------------------------------
module gsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/gsd_front.sv -----
// ----------------------------------------------------------------------------
// gsd_front
// Register file on the config port and intake of mode requests.
// ----------------------------------------------------------------------------
module gsd_front #(
  parameter int CHANNELS = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic [7:0]     pixel_c0_i,
  input  logic [7:0]     pixel_c1_i,
  input  logic [7:0]     pixel_c2_i,
  input  logic [15:0]    mean_c0_i,
  input  logic [15:0]    mean_c1_i,
  input  logic [15:0]    mean_c2_i,
  input  logic [15:0]    mode_weight_i,
  input  logic [15:0]    mode_variance_i,
  input  logic           last_mode_i,
  output gsd_pkg::mode_t mode_o,
  output gsd_pkg::cfg_t  cfg_o
);
  import gsd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_THRESHOLD: cfg_d.threshold = pwdata[15:0];
        REG_BG_RATIO:  cfg_d.bg_ratio  = pwdata[15:0];
        REG_TAU:       cfg_d.tau       = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{threshold: THRESHOLD_RST, bg_ratio: BG_RATIO_RST, tau: TAU_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold};
      REG_BG_RATIO:  prdata = {16'd0, cfg_q.bg_ratio};
      REG_TAU:       prdata = {16'd0, cfg_q.tau};
      default:       prdata = '0;
    endcase
  end

  // unused channels are forced to zero so they drop out of every sum
  always_comb begin
    mode_o.pixel_c0      = pixel_c0_i;
    mode_o.mean_c0       = mean_c0_i;
    mode_o.pixel_c1      = (CHANNELS > 1) ? pixel_c1_i : '0;
    mode_o.mean_c1       = (CHANNELS > 1) ? mean_c1_i : '0;
    mode_o.pixel_c2      = (CHANNELS > 2) ? pixel_c2_i : '0;
    mode_o.mean_c2       = (CHANNELS > 2) ? mean_c2_i : '0;
    mode_o.mode_weight   = mode_weight_i;
    mode_o.mode_variance = mode_variance_i;
    mode_o.last_mode     = last_mode_i;
  end

endmodule

// ----- hw/rtl/gsd_back.sv -----
// ----------------------------------------------------------------------------
// gsd_back
// Sequencer that runs the shadow test of one mode on a shared multiplier.
// ----------------------------------------------------------------------------
module gsd_back #(
  parameter int CHANNELS = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gsd_pkg::cfg_t  cfg_i,
  input  gsd_pkg::mode_t mode_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           is_shadow_o,
  output logic [1:0]     decided_by_o
);
  import gsd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_N1, ST_N2, ST_D0, ST_D1, ST_D2, ST_TV, ST_WIN, ST_CHK,
    ST_NN, ST_R0, ST_R1, ST_R2, ST_X, ST_Y, ST_DF, ST_L0, ST_L1, ST_L2,
    ST_L3, ST_CMP, ST_WT, ST_FIN
  } state_e;

  state_e      state_q;
  logic [33:0] mul_a;
  logic [25:0] mul_b;
  logic [59:0] prod_q;
  logic [25:0] num_q;
  logic [33:0] den_q;
  logic [31:0] tv_q;
  logic [51:0] nn_q;
  logic [85:0] rhs_q, lhs_q;
  logic [41:0] x_q, dd_q;
  logic [1:0]  ch_q;
  logic [18:0] wsum_q;
  logic        res_q, res_shadow_q;
  logic [1:0]  res_reason_q;
  logic        out_valid_q, is_shadow_q;
  logic [1:0]  decided_q;
  logic [7:0]  pc;
  logic [15:0] mc;
  logic [19:0] wsum_add;
  logic        win_ok, fin_go;

  assign out_valid_o  = out_valid_q;
  assign is_shadow_o  = is_shadow_q;
  assign decided_by_o = decided_q;

  // channel select for the distortion loop
  always_comb begin
    case (ch_q)
      2'd0:    begin pc = mode_i.pixel_c0; mc = mode_i.mean_c0; end
      2'd1:    begin pc = mode_i.pixel_c1; mc = mode_i.mean_c1; end
      default: begin pc = mode_i.pixel_c2; mc = mode_i.mean_c2; end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IDLE: begin mul_a = 34'(mode_i.pixel_c0); mul_b = 26'(mode_i.mean_c0); end
      ST_N1:   begin mul_a = 34'(mode_i.pixel_c1); mul_b = 26'(mode_i.mean_c1); end
      ST_N2:   begin mul_a = 34'(mode_i.pixel_c2); mul_b = 26'(mode_i.mean_c2); end
      ST_D0:   begin mul_a = 34'(mode_i.mean_c0);  mul_b = 26'(mode_i.mean_c0);  end
      ST_D1:   begin mul_a = 34'(mode_i.mean_c1);  mul_b = 26'(mode_i.mean_c1);  end
      ST_D2:   begin mul_a = 34'(mode_i.mean_c2);  mul_b = 26'(mode_i.mean_c2);  end
      ST_TV:   begin mul_a = 34'(cfg_i.threshold); mul_b = 26'(mode_i.mode_variance); end
      ST_WIN:  begin mul_a = den_q;                mul_b = 26'(cfg_i.tau); end
      ST_CHK:  begin mul_a = 34'(num_q);           mul_b = num_q; end
      ST_R0:   begin mul_a = 34'(tv_q);            mul_b = nn_q[25:0]; end
      ST_R1:   begin mul_a = 34'(tv_q);            mul_b = nn_q[51:26]; end
      ST_X:    begin mul_a = 34'(num_q);           mul_b = 26'(mc); end
      ST_Y:    begin mul_a = den_q;                mul_b = 26'(pc); end
      ST_L0:   begin mul_a = 34'(dd_q[20:0]);      mul_b = 26'(dd_q[20:0]); end
      ST_L1:   begin mul_a = 34'(dd_q[41:21]);     mul_b = 26'(dd_q[20:0]); end
      ST_L2:   begin mul_a = 34'(dd_q[41:21]);     mul_b = 26'(dd_q[41:21]); end
      default: begin mul_a = '0;                   mul_b = '0; end
    endcase
  end

  // ratio window: n*2^8 <= d and n*2^24 >= tau*d
  assign win_ok = ({num_q, 8'd0} <= den_q) && ({num_q, 24'd0} >= prod_q[49:0]);
  assign wsum_add = {1'b0, wsum_q} + 20'(mode_i.mode_weight);
  // a mode can finish unless it is a last mode and the output register holds an untaken result
  assign fin_go = !mode_i.last_mode || !out_valid_q || out_ready_i;
  assign pop_o  = (state_q == ST_FIN) && fin_go;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // sequencer, pixel state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= '0;
      wsum_q       <= '0;
      res_q        <= 1'b0;
      res_shadow_q <= 1'b0;
      res_reason_q <= REASON_NONE;
      out_valid_q  <= 1'b0;
      is_shadow_q  <= 1'b0;
      decided_q    <= REASON_NONE;
      num_q        <= '0;
      den_q        <= '0;
      tv_q         <= '0;
      nn_q         <= '0;
      rhs_q        <= '0;
      lhs_q        <= '0;
      x_q          <= '0;
      dd_q         <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !(pop_o && mode_i.last_mode)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            state_q <= res_q ? ST_FIN : ST_N1;
          end
        end
        ST_N1: begin num_q <= prod_q[25:0];           state_q <= ST_N2; end
        ST_N2: begin num_q <= num_q + prod_q[25:0];   state_q <= ST_D0; end
        ST_D0: begin num_q <= num_q + prod_q[25:0];   state_q <= ST_D1; end
        ST_D1: begin den_q <= prod_q[33:0];           state_q <= ST_D2; end
        ST_D2: begin den_q <= den_q + prod_q[33:0];   state_q <= ST_TV; end
        ST_TV: begin den_q <= den_q + prod_q[33:0];   state_q <= ST_WIN; end
        ST_WIN: begin
          tv_q <= prod_q[31:0];
          if (den_q == '0) begin
            res_q        <= 1'b1;
            res_shadow_q <= 1'b0;
            res_reason_q <= REASON_ZERO;
            state_q      <= ST_FIN;
          end else begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: state_q <= win_ok ? ST_NN : ST_WT;
        ST_NN:  begin nn_q <= prod_q[51:0]; state_q <= ST_R0; end
        ST_R0:  state_q <= ST_R1;
        ST_R1:  begin rhs_q <= 86'(prod_q[57:0]); state_q <= ST_R2; end
        ST_R2: begin
          rhs_q   <= rhs_q + (86'(prod_q[57:0]) << 26);
          lhs_q   <= '0;
          ch_q    <= '0;
          state_q <= ST_X;
        end
        ST_X: state_q <= ST_Y;
        ST_Y: begin x_q <= prod_q[41:0]; state_q <= ST_DF; end
        // absolute difference of n*m and p*d
        ST_DF: begin
          dd_q    <= (x_q >= prod_q[41:0]) ? x_q - prod_q[41:0] : prod_q[41:0] - x_q;
          state_q <= ST_L0;
        end
        ST_L0: state_q <= ST_L1;
        ST_L1: begin lhs_q <= lhs_q + 86'(prod_q[41:0]); state_q <= ST_L2; end
        ST_L2: begin lhs_q <= lhs_q + (86'(prod_q[41:0]) << 22); state_q <= ST_L3; end
        ST_L3: begin
          lhs_q <= lhs_q + (86'(prod_q[41:0]) << 42);
          if (ch_q == 2'(CHANNELS - 1)) begin
            state_q <= ST_CMP;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_X;
          end
        end
        ST_CMP: begin
          if (lhs_q < rhs_q) begin
            res_q        <= 1'b1;
            res_shadow_q <= 1'b1;
            res_reason_q <= REASON_SHADOW;
            state_q      <= ST_FIN;
          end else begin
            state_q <= ST_WT;
          end
        end
        // saturating weight sum and the weight decision
        ST_WT: begin
          if (wsum_add[19]) begin
            wsum_q <= WSUM_MAX;
          end else begin
            wsum_q <= wsum_add[18:0];
          end
          if ((wsum_add[19] ? WSUM_MAX : wsum_add[18:0]) > 19'(cfg_i.bg_ratio)) begin
            res_q        <= 1'b1;
            res_shadow_q <= 1'b0;
            res_reason_q <= REASON_WEIGHT;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            if (mode_i.last_mode) begin
              out_valid_q  <= 1'b1;
              is_shadow_q  <= res_shadow_q;
              decided_q    <= res_reason_q;
              wsum_q       <= '0;
              res_q        <= 1'b0;
              res_shadow_q <= 1'b0;
              res_reason_q <= REASON_NONE;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gmm_shadow_detector_unit.sv -----
// ----------------------------------------------------------------------------
// gmm_shadow_detector_unit
// Shadow test of a pixel against its mixture modes, one mode per request.
// ----------------------------------------------------------------------------
//   channel  | handshake                | payload
//   mode in  | in_valid_i / in_ready_o  | pixel_c0..2, mean_c0..2, weight, var, last
//   result   | out_valid_o / out_ready_i| is_shadow_o, decided_by_o
//   config   | psel, penable, pwrite    | paddr, pwdata, prdata
//
// a mode of an already decided pixel goes straight to the finish; otherwise the
// sequencer stops at a zero mean, goes to the weight test when the ratio is out
// of window, and else runs the distortion test over CHANNELS channels; every
// product comes from the single shared 34x26 multiplier.
// a FIFO_DEPTH queue lets modes be taken while the sequencer is busy.
// reset clears the config registers to their defaults and the pixel state.
// a result waits in the output register; the sequencer stalls only on a last mode.
module gmm_shadow_detector_unit #(
  parameter int CHANNELS   = 3,
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_c0_i,
  input  logic [7:0]  pixel_c1_i,
  input  logic [7:0]  pixel_c2_i,
  input  logic [15:0] mean_c0_i,
  input  logic [15:0] mean_c1_i,
  input  logic [15:0] mean_c2_i,
  input  logic [15:0] mode_weight_i,
  input  logic [15:0] mode_variance_i,
  input  logic        last_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_shadow_o,
  output logic [1:0]  decided_by_o
);
  import gsd_pkg::*;

  mode_t in_mode, head_mode;
  cfg_t  cfg;
  logic  full, empty, pop;

  assign in_ready_o = !full;

  // front: config registers and intake
  gsd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pixel_c0_i, .pixel_c1_i, .pixel_c2_i, .mean_c0_i, .mean_c1_i, .mean_c2_i,
    .mode_weight_i, .mode_variance_i, .last_mode_i,
    .mode_o (in_mode),
    .cfg_o  (cfg)
  );

  // queue between front and back
  gsd_fifo #(.WIDTH($bits(mode_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (in_valid_i),
    .wdata_i (in_mode),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_mode),
    .empty_o (empty)
  );

  // back: per-mode test sequencer
  gsd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i, .rst_ni,
    .cfg_i   (cfg),
    .mode_i  (head_mode),
    .empty_i (empty),
    .pop_o   (pop),
    .out_valid_o, .out_ready_i, .is_shadow_o, .decided_by_o
  );

endmodule

// ----- hw/rtl/gsd_checker.sv -----
// ----------------------------------------------------------------------------
// gsd_checker
// Port-level checks of the shadow detector, bound to the top level.
// ----------------------------------------------------------------------------
module gsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       is_shadow_o,
  input logic [1:0] decided_by_o
);
  import gsd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_shadow_o)
      && $stable(decided_by_o))
    else $error("result changed while stalled");

  // shadow flag only with the shadow reason
  a_shadow_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_shadow_o |-> decided_by_o == REASON_SHADOW)
    else $error("shadow flag with wrong reason");

  // shadow reason only with the shadow flag
  a_reason_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decided_by_o == REASON_SHADOW |-> is_shadow_o)
    else $error("shadow reason without flag");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind gmm_shadow_detector_unit gsd_checker u_gsd_checker (
  .clk_i, .rst_ni, .pready, .out_valid_o, .out_ready_i, .is_shadow_o, .decided_by_o
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gmm_shadow_detector_unit: streams mixture modes
// per pixel with random gaps and output stalls, predicts each pixel decision
// in exact wide arithmetic and compares it with every result taken.
// ----------------------------------------------------------------------------
module tb;
  import gsd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct packed {
    logic       shadow;
    logic [1:0] reason;
  } decision_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o;
  logic [7:0]  pixel_c0_i, pixel_c1_i, pixel_c2_i;
  logic [15:0] mean_c0_i, mean_c1_i, mean_c2_i, mode_weight_i, mode_variance_i;
  logic        last_mode_i;
  logic        out_valid_o, out_ready_i, is_shadow_o;
  logic [1:0]  decided_by_o;

  // predictor state and its copy of the registers
  logic [15:0] thr_q, bgr_q, tau_q;
  logic [18:0] wsum_q;
  logic        done_q, dshadow_q;
  logic [1:0]  dreason_q;
  decision_t   pending_decisions[$];

  int  mismatches;
  int  cycles;
  bit  no_idle;

  gmm_shadow_detector_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (no_idle) out_ready_i <= 1'b1;
    else out_ready_i <= (gap_len() == 0);
  end

  // compare each result with the oldest pending decision
  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_decisions.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result shadow=%0b by=%0d",
                                      is_shadow_o, decided_by_o);
      end else begin
        want = pending_decisions.pop_front();
        if (want.shadow !== is_shadow_o || want.reason !== decided_by_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp shadow=%0b by=%0d, got shadow=%0b by=%0d",
                     want.shadow, want.reason, is_shadow_o, decided_by_o);
        end
      end
    end
  end

  function automatic void clear_pixel_state();
    wsum_q = '0;
    done_q = 1'b0;
    dshadow_q = 1'b0;
    dreason_q = REASON_NONE;
  endfunction

  // exact decision for one mode, cross-multiplied
  function automatic void judge_mode(mode_t m);
    logic [63:0]  num, den, px[3], mn[3];
    logic [127:0] lhs, rhs, x, y, d;
    logic [19:0]  wnext;
    decision_t    res;
    px[0] = m.pixel_c0; px[1] = m.pixel_c1; px[2] = m.pixel_c2;
    mn[0] = m.mean_c0;  mn[1] = m.mean_c1;  mn[2] = m.mean_c2;
    if (!done_q) begin
      num = 0; den = 0;
      for (int c = 0; c < 3; c++) begin
        num += px[c] * mn[c];
        den += mn[c] * mn[c];
      end
      if (den == 0) begin
        done_q = 1'b1; dshadow_q = 1'b0; dreason_q = REASON_ZERO;
      end else begin
        if ((num << 8) <= den && (num << 24) >= 64'(tau_q) * den) begin
          lhs = '0;
          for (int c = 0; c < 3; c++) begin
            x = 128'(num) * 128'(mn[c]);
            y = 128'(px[c]) * 128'(den);
            d = (x >= y) ? x - y : y - x;
            lhs += d * d;
          end
          rhs = 128'(thr_q) * 128'(m.mode_variance) * 128'(num) * 128'(num);
          if (lhs < rhs) begin
            done_q = 1'b1; dshadow_q = 1'b1; dreason_q = REASON_SHADOW;
          end
        end
        if (!done_q) begin
          wnext = 20'(wsum_q) + 20'(m.mode_weight);
          wsum_q = (wnext > 20'(WSUM_MAX)) ? WSUM_MAX : wnext[18:0];
          if (wsum_q > 19'(bgr_q)) begin
            done_q = 1'b1; dshadow_q = 1'b0; dreason_q = REASON_WEIGHT;
          end
        end
      end
    end
    if (m.last_mode) begin
      res.shadow = done_q ? dshadow_q : 1'b0;
      res.reason = done_q ? dreason_q : REASON_NONE;
      pending_decisions.push_back(res);
      clear_pixel_state();
    end
  endfunction

  // one mode request on the input channel
  task automatic send_mode(mode_t m);
    int g;
    in_valid_i      <= 1'b1;
    pixel_c0_i      <= m.pixel_c0;
    pixel_c1_i      <= m.pixel_c1;
    pixel_c2_i      <= m.pixel_c2;
    mean_c0_i       <= m.mean_c0;
    mean_c1_i       <= m.mean_c1;
    mean_c2_i       <= m.mean_c2;
    mode_weight_i   <= m.mode_weight;
    mode_variance_i <= m.mode_variance;
    last_mode_i     <= m.last_mode;
    do @(posedge clk_i); while (!in_ready_o);
    judge_mode(m);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_q = value;
      REG_BG_RATIO:  bgr_q = value;
      REG_TAU:       tau_q = value;
      default: ;
    endcase
  endtask

  // let every pending decision come back, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic mode_t make_mode(logic [7:0] p0, p1, p2, logic [15:0] m0, m1, m2,
                                      logic [15:0] w, v, logic last);
    mode_t m;
    m.pixel_c0 = p0; m.pixel_c1 = p1; m.pixel_c2 = p2;
    m.mean_c0 = m0; m.mean_c1 = m1; m.mean_c2 = m2;
    m.mode_weight = w; m.mode_variance = v; m.last_mode = last;
    return m;
  endfunction

  // mean close to pixel scaled by 1/ratio, so the ratio window is often hit
  function automatic logic [15:0] near_mean(logic [7:0] p, int f);
    int v;
    v = (int'(p) * 256 * f) / 1024 + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // one pixel with a random number of modes
  task automatic send_pixel(bit shaped, bit gray);
    int     n, f;
    mode_t  m;
    logic [7:0] p0, p1, p2;
    n  = $urandom_range(1, 5);
    p0 = 8'($urandom); p1 = gray ? 8'd0 : 8'($urandom); p2 = gray ? 8'd0 : 8'($urandom);
    for (int i = 0; i < n; i++) begin
      m = make_mode(p0, p1, p2, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), i == n - 1);
      if (shaped) begin
        f = $urandom_range(1000, 2200);
        m.mean_c0 = near_mean(p0, f);
        m.mean_c1 = gray ? 16'd0 : near_mean(p1, f);
        m.mean_c2 = gray ? 16'd0 : near_mean(p2, f);
        if ($urandom_range(0, 3) != 0) m.mode_weight = 16'($urandom_range(0, 30000));
        if ($urandom_range(0, 2) == 0) m.mode_variance = 16'($urandom_range(0, 64));
      end
      if ($urandom_range(0, 29) == 0) begin
        m.mean_c0 = 0; m.mean_c1 = 0; m.mean_c2 = 0;
      end
      send_mode(m);
    end
  endtask

  // field extremes and each special case under reset settings
  task automatic test_directed();
    no_idle = 1'b1;
    send_mode(make_mode(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 1'b1));
    send_mode(make_mode(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // zero mean decides, later modes ignored
    send_mode(make_mode(10, 20, 30, 0, 0, 0, 16'h1234, 100, 1'b0));
    send_mode(make_mode(100, 100, 100, 25600, 25600, 25600, 100, 50, 1'b1));
    // exact shadow, brightness ratio one
    send_mode(make_mode(100, 100, 100, 25600, 25600, 25600, 100, 50, 1'b1));
    // zero variance fails the distortion test, then weight decides
    send_mode(make_mode(100, 100, 100, 25600, 25600, 25600, 40000, 0, 1'b0));
    send_mode(make_mode(100, 100, 100, 25600, 25600, 25600, 40000, 0, 1'b1));
    // no mode decides
    send_mode(make_mode(1, 2, 3, 16'h8000, 16'h0100, 16'h0001, 10, 5, 1'b0));
    send_mode(make_mode(1, 2, 3, 16'h4000, 16'h0200, 16'h0002, 10, 5, 1'b1));
    // grayscale shadow at ratio one half
    send_mode(make_mode(80, 0, 0, 40960, 0, 0, 5, 20, 1'b1));
    // weight decides on the first mode, later modes ignored
    repeat (3) send_mode(make_mode(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 0, 1'b0));
    send_mode(make_mode(0, 0, 0, 1, 1, 1, 16'hFFFF, 0, 1'b1));
    no_idle = 1'b0;
    drain();
  endtask

  // register extremes, unknown index, zero ratio with tau at zero
  task automatic test_config_extremes();
    write_reg(REG_TAU, 16'd0);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_BG_RATIO, 16'hFFFF);
    write_reg(2'd3, 16'h0000);
    send_mode(make_mode(0, 0, 0, 500, 600, 700, 16'hFFFF, 16'hFFFF, 1'b1));
    send_mode(make_mode(0, 9, 0, 500, 600, 700, 300, 16'hFFFF, 1'b1));
    repeat (10) send_pixel(1'b1, 1'b0);
    drain();
    write_reg(REG_TAU, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_BG_RATIO, 16'd0);
    send_mode(make_mode(100, 100, 100, 25600, 25600, 25600, 1, 16'hFFFF, 1'b1));
    send_mode(make_mode(100, 100, 100, 25600, 25600, 25600, 0, 16'hFFFF, 1'b1));
    repeat (10) send_pixel(1'b1, 1'b0);
    drain();
  endtask

  // random pixels over several register settings
  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_THRESHOLD, phase == 0 ? THRESHOLD_RST : 16'($urandom));
      write_reg(REG_BG_RATIO, phase == 0 ? BG_RATIO_RST : 16'($urandom));
      write_reg(REG_TAU, phase == 0 ? TAU_RST : 16'($urandom_range(0, 65535)));
      no_idle = (phase == 3);
      for (int k = 0; k < 18; k++) begin
        if ($urandom_range(0, 4) == 0) send_pixel(1'b0, 1'b0);
        else send_pixel(1'b1, $urandom_range(0, 5) == 0);
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    no_idle = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0;
    pixel_c0_i <= '0; pixel_c1_i <= '0; pixel_c2_i <= '0;
    mean_c0_i <= '0; mean_c1_i <= '0; mean_c2_i <= '0;
    mode_weight_i <= '0; mode_variance_i <= '0; last_mode_i <= 1'b0;
    out_ready_i <= 1'b0;
    thr_q = THRESHOLD_RST; bgr_q = BG_RATIO_RST; tau_q = TAU_RST;
    clear_pixel_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    if (mismatches == 0 && pending_decisions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
